FILE: sv/ams_pkg.sv
// ----------------------------------------------------------------------------
// Alignment match statistics package
// Shared types, item kinds, field widths and character codes used by the
// alignment statistics block and its submodules.
// ----------------------------------------------------------------------------
package ams_pkg;

	// Field widths of the stream items.
	localparam int unsigned BASE_W   = 8;
	localparam int unsigned COORD_W  = 32;
	localparam int unsigned WIDE_W   = 2 * COORD_W;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned TOTAL_W  = 32;

	// Packed stream payload widths.
	localparam int unsigned IN_DATA_W  = 152;
	localparam int unsigned NUM_TOTALS = 9;
	localparam int unsigned OUT_DATA_W = NUM_TOTALS * TOTAL_W;

	// Item kinds carried in tuser.
	localparam logic [KIND_W-1:0] KIND_BLOCK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BASE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

	// Places of the totals in the accumulator array and in the result.
	localparam int unsigned TOT_MATCH     = 0;
	localparam int unsigned TOT_MISMATCH  = 1;
	localparam int unsigned TOT_REPEAT    = 2;
	localparam int unsigned TOT_UNKNOWN   = 3;
	localparam int unsigned TOT_Q_GAP_CNT = 4;
	localparam int unsigned TOT_Q_GAP_BAS = 5;
	localparam int unsigned TOT_T_GAP_CNT = 6;
	localparam int unsigned TOT_T_GAP_BAS = 7;
	localparam int unsigned TOT_BLOCK     = 8;

	// Character codes.
	localparam logic [BASE_W-1:0] CHAR_N       = 8'h4E;
	localparam logic [BASE_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [BASE_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [BASE_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [BASE_W-1:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [BASE_W-1:0] CASE_OFFSET  = 8'h20;

	// Outcome of one aligned base pair; exactly one bit is set.
	typedef struct packed {
		logic unknown;
		logic match;
		logic repeat_match;
		logic mismatch;
	} base_class_t;

	// One item retiring from the input stage into the accumulators.
	typedef struct packed {
		logic                fire;
		logic [KIND_W-1:0]   kind;
		base_class_t         cls;
		logic [COORD_W-1:0]  q_start;
		logic [COORD_W-1:0]  q_end;
		logic [COORD_W-1:0]  t_start;
		logic [COORD_W-1:0]  t_end;
	} step_t;

endpackage

FILE: sv/alignment_match_statistics.sv
// ----------------------------------------------------------------------------
// Alignment match statistics
// Collects match, mismatch, repeat, unknown, gap and block totals of one
// chain from a stream of block, base and finish items.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle. Each transfer lands in an input
// register; the classifier and the accumulators absorb it as it retires from
// there, and a finish item of a non-empty chain loads the totals into the output
// register, which offers the result until it is taken. The input side stalls
// only while a finish item waits for the output register to be taken. Totals are
// the low 32 bits of COUNT_WIDTH-bit wrapping counters.
module alignment_match_statistics #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// From bit 0: query_base[8], target_base[8], block_q_start[32],
	// block_q_end[32], block_t_start[32], block_t_end[32], chain_empty[1],
	// then zero fill.
	input  logic [ams_pkg::IN_DATA_W-1:0]    s_tdata,
	// kind[2]
	input  logic [ams_pkg::KIND_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// From bit 0, 32 bits each: match_total, mismatch_total,
	// repeat_match_total, unknown_base_total, query_gap_count,
	// query_gap_bases, target_gap_count, target_gap_bases, block_total.
	output logic [ams_pkg::OUT_DATA_W-1:0]   m_tdata
);

	logic                                            valid_s1;
	logic [ams_pkg::KIND_W-1:0]                      kind_s1;
	logic [ams_pkg::BASE_W-1:0]                      q_base_s1;
	logic [ams_pkg::BASE_W-1:0]                      t_base_s1;
	logic [ams_pkg::COORD_W-1:0]                     q_start_s1;
	logic [ams_pkg::COORD_W-1:0]                     q_end_s1;
	logic [ams_pkg::COORD_W-1:0]                     t_start_s1;
	logic [ams_pkg::COORD_W-1:0]                     t_end_s1;
	logic                                            empty_s1;
	logic                                            emits_s1;
	logic                                            retire_s1;
	logic                                            out_free;
	ams_pkg::base_class_t                            cls;
	ams_pkg::step_t                                  step;
	logic [ams_pkg::NUM_TOTALS-1:0][COUNT_WIDTH-1:0] totals;
	logic [ams_pkg::OUT_DATA_W-1:0]                  result_word;
	logic                                            m_valid_q;
	logic [ams_pkg::OUT_DATA_W-1:0]                  m_data_q;

	// Stage flow: an emitting finish needs a free output register.
	assign out_free  = !m_valid_q || m_tready;
	assign emits_s1  = (kind_s1 == ams_pkg::KIND_FINISH) && !empty_s1;
	assign retire_s1 = valid_s1 && (!emits_s1 || out_free);
	assign s_tready  = !valid_s1 || retire_s1;

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload, captured on each transfer.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1    <= s_tuser;
			q_base_s1  <= s_tdata[7:0];
			t_base_s1  <= s_tdata[15:8];
			q_start_s1 <= s_tdata[47:16];
			q_end_s1   <= s_tdata[79:48];
			t_start_s1 <= s_tdata[111:80];
			t_end_s1   <= s_tdata[143:112];
			empty_s1   <= s_tdata[144];
		end
	end

	ams_classify u_classify (
		.query_base  (q_base_s1),
		.target_base (t_base_s1),
		.cls         (cls)
	);

	assign step.fire    = retire_s1;
	assign step.kind    = kind_s1;
	assign step.cls     = cls;
	assign step.q_start = q_start_s1;
	assign step.q_end   = q_end_s1;
	assign step.t_start = t_start_s1;
	assign step.t_end   = t_end_s1;

	ams_accum #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.totals (totals)
	);

	// Pack the totals into 32-bit result words.
	for (genvar i = 0; i < ams_pkg::NUM_TOTALS; i++) begin : g_pack
		assign result_word[i*ams_pkg::TOTAL_W +: ams_pkg::TOTAL_W] =
			ams_pkg::TOTAL_W'(totals[i]);
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (retire_s1 && emits_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (retire_s1 && emits_s1) begin
			m_data_q <= result_word;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// An emitting finish always shows up in the output register.
	a_finish_emits: assert property (@(posedge clk) disable iff (!arst_n)
		retire_s1 && emits_s1 |=> m_tvalid)
		else $error("finish result was not loaded into the output register");

	// A base pair falls into exactly one class.
	a_class_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		retire_s1 && kind_s1 == ams_pkg::KIND_BASE |-> $onehot(cls))
		else $error("base pair classification is not one-hot");

	// A finish leaves the chain totals cleared.
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		retire_s1 && kind_s1 == ams_pkg::KIND_FINISH |=> totals == '0)
		else $error("totals not cleared after finish");

	// The input side stalls only behind a blocked result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && emits_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a blocked result");

endmodule

FILE: sv/ams_classify.sv
// ----------------------------------------------------------------------------
// Base pair classifier
// Folds both bytes to uppercase and sorts the pair into unknown, match,
// repeat match or mismatch.
// ----------------------------------------------------------------------------
module ams_classify (
	input  logic [ams_pkg::BASE_W-1:0] query_base,
	input  logic [ams_pkg::BASE_W-1:0] target_base,
	output ams_pkg::base_class_t       cls
);

	logic [ams_pkg::BASE_W-1:0] q_fold;
	logic [ams_pkg::BASE_W-1:0] t_fold;
	logic                       t_upper;
	logic                       unknown;
	logic                       equal;

	// Only the letters a to z are folded; other bytes pass unchanged.
	always_comb begin
		q_fold = query_base;
		t_fold = target_base;
		if (query_base >= ams_pkg::CHAR_LOWER_A && query_base <= ams_pkg::CHAR_LOWER_Z) begin
			q_fold = query_base - ams_pkg::CASE_OFFSET;
		end
		if (target_base >= ams_pkg::CHAR_LOWER_A && target_base <= ams_pkg::CHAR_LOWER_Z) begin
			t_fold = target_base - ams_pkg::CASE_OFFSET;
		end
	end

	// An N on either side wins; otherwise target case picks match or repeat.
	assign unknown = (q_fold == ams_pkg::CHAR_N) || (t_fold == ams_pkg::CHAR_N);
	assign t_upper = (target_base >= ams_pkg::CHAR_UPPER_A)
		&& (target_base <= ams_pkg::CHAR_UPPER_Z);
	assign equal   = (q_fold == t_fold);

	assign cls.unknown      = unknown;
	assign cls.match        = !unknown && t_upper && equal;
	assign cls.repeat_match = !unknown && !t_upper && equal;
	assign cls.mismatch     = !unknown && !equal;

endmodule

FILE: sv/ams_accum.sv
// ----------------------------------------------------------------------------
// Chain accumulators
// Holds the running totals, the previous block ends and the block-seen flag,
// and updates them for each item that retires from the input stage.
// ----------------------------------------------------------------------------
module ams_accum #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  ams_pkg::step_t                                   step,
	output logic [ams_pkg::NUM_TOTALS-1:0][COUNT_WIDTH-1:0] totals
);

	logic [ams_pkg::NUM_TOTALS-1:0][COUNT_WIDTH-1:0] acc_q;
	logic [ams_pkg::COORD_W-1:0]                     prev_q_end_q;
	logic [ams_pkg::COORD_W-1:0]                     prev_t_end_q;
	logic                                            have_prev_q;
	logic [ams_pkg::WIDE_W-1:0]                      q_diff_wide;
	logic [ams_pkg::WIDE_W-1:0]                      t_diff_wide;
	logic [COUNT_WIDTH-1:0]                          q_gap;
	logic [COUNT_WIDTH-1:0]                          t_gap;

	// Gap sizes; a backward step yields the wrapped difference.
	assign q_diff_wide = {{ams_pkg::COORD_W{1'b0}}, step.q_start}
		- {{ams_pkg::COORD_W{1'b0}}, prev_q_end_q};
	assign t_diff_wide = {{ams_pkg::COORD_W{1'b0}}, step.t_start}
		- {{ams_pkg::COORD_W{1'b0}}, prev_t_end_q};
	assign q_gap = q_diff_wide[COUNT_WIDTH-1:0];
	assign t_gap = t_diff_wide[COUNT_WIDTH-1:0];

	// Accumulator update per item kind; a finish clears the whole chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			prev_q_end_q <= '0;
			prev_t_end_q <= '0;
			have_prev_q  <= 1'b0;
		end else if (step.fire) begin
			case (step.kind)
				ams_pkg::KIND_BLOCK: begin
					if (have_prev_q && step.q_start != prev_q_end_q) begin
						acc_q[ams_pkg::TOT_Q_GAP_CNT] <= acc_q[ams_pkg::TOT_Q_GAP_CNT]
							+ COUNT_WIDTH'(1);
						acc_q[ams_pkg::TOT_Q_GAP_BAS] <= acc_q[ams_pkg::TOT_Q_GAP_BAS] + q_gap;
					end
					if (have_prev_q && step.t_start != prev_t_end_q) begin
						acc_q[ams_pkg::TOT_T_GAP_CNT] <= acc_q[ams_pkg::TOT_T_GAP_CNT]
							+ COUNT_WIDTH'(1);
						acc_q[ams_pkg::TOT_T_GAP_BAS] <= acc_q[ams_pkg::TOT_T_GAP_BAS] + t_gap;
					end
					acc_q[ams_pkg::TOT_BLOCK] <= acc_q[ams_pkg::TOT_BLOCK] + COUNT_WIDTH'(1);
					prev_q_end_q <= step.q_end;
					prev_t_end_q <= step.t_end;
					have_prev_q  <= 1'b1;
				end
				ams_pkg::KIND_BASE: begin
					if (step.cls.unknown) begin
						acc_q[ams_pkg::TOT_UNKNOWN] <= acc_q[ams_pkg::TOT_UNKNOWN]
							+ COUNT_WIDTH'(1);
					end
					if (step.cls.match) begin
						acc_q[ams_pkg::TOT_MATCH] <= acc_q[ams_pkg::TOT_MATCH] + COUNT_WIDTH'(1);
					end
					if (step.cls.repeat_match) begin
						acc_q[ams_pkg::TOT_REPEAT] <= acc_q[ams_pkg::TOT_REPEAT]
							+ COUNT_WIDTH'(1);
					end
					if (step.cls.mismatch) begin
						acc_q[ams_pkg::TOT_MISMATCH] <= acc_q[ams_pkg::TOT_MISMATCH]
							+ COUNT_WIDTH'(1);
					end
				end
				ams_pkg::KIND_FINISH: begin
					acc_q        <= '0;
					prev_q_end_q <= '0;
					prev_t_end_q <= '0;
					have_prev_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign totals = acc_q;

endmodule
